// ===== rtl/tspg_pkg.sv =====
// ----------------------------------------------------------------------------
// tspg_pkg
// Shared types and constants of the textured span pixel generator.
// ----------------------------------------------------------------------------
package tspg_pkg;

    localparam int TEX_AW   = 12;
    localparam int FADE_AW  = 16;
    localparam int ACC_W    = 32;
    localparam int PAYLOAD_W = 280;

    typedef enum logic [1:0] {
        CMD_LOAD_TEXEL = 2'd0,
        CMD_LOAD_FADE  = 2'd1,
        CMD_START      = 2'd2,
        CMD_EMIT       = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_TRANSPARENCY = 2'd0,
        REG_PERSPECTIVE  = 2'd1,
        REG_LIGHTING     = 2'd2,
        REG_TRANS_INDEX  = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic       transp_en;
        logic       perspective_on;
        logic       lighting_on;
        logic [7:0] transparent_index;
    } cfg_t;

    // one request handed from front to back
    typedef struct packed {
        cmd_t             cmd;
        logic [15:0]      addr;
        logic [7:0]       data;
        logic [ACC_W-1:0] u;
        logic [ACC_W-1:0] v;
        logic [ACC_W-1:0] z;
        logic [7:0]       light_row;
    } work_t;

endpackage

// ===== rtl/tspg_front.sv =====
// ----------------------------------------------------------------------------
// tspg_front
// Accepts requests, keeps the span accumulators and forwards work to the queue.
// ----------------------------------------------------------------------------
module tspg_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [tspg_pkg::PAYLOAD_W-1:0]   s_tdata,
    input  logic [1:0]                       s_tuser,
    input  logic                             q_full,
    output logic                             q_push,
    output tspg_pkg::work_t                  q_wdata
);
    import tspg_pkg::*;

    logic [ACC_W-1:0] u_accum_reg, v_accum_reg, z_accum_reg, light_accum_reg;
    logic [ACC_W-1:0] u_delta_reg, v_delta_reg, z_delta_reg, light_delta_reg;
    logic             accept;
    cmd_t             cmd;

    assign cmd      = cmd_t'(s_tuser);
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    // span start only updates local state
    assign q_push   = accept && (cmd != CMD_START);

    always_comb begin
        q_wdata.cmd       = cmd;
        q_wdata.addr      = s_tdata[15:0];
        q_wdata.data      = s_tdata[23:16];
        q_wdata.u         = u_accum_reg;
        q_wdata.v         = v_accum_reg;
        q_wdata.z         = z_accum_reg;
        q_wdata.light_row = light_accum_reg[15:8];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            u_accum_reg     <= '0;
            v_accum_reg     <= '0;
            z_accum_reg     <= '0;
            light_accum_reg <= '0;
            u_delta_reg     <= '0;
            v_delta_reg     <= '0;
            z_delta_reg     <= '0;
            light_delta_reg <= '0;
        end else if (accept) begin
            if (cmd == CMD_START) begin
                u_accum_reg     <= s_tdata[55:24];
                v_accum_reg     <= {s_tdata[81:56], 6'd0};
                z_accum_reg     <= s_tdata[119:88];
                light_accum_reg <= s_tdata[151:120];
                u_delta_reg     <= s_tdata[183:152];
                v_delta_reg     <= {s_tdata[209:184], 6'd0};
                z_delta_reg     <= s_tdata[247:216];
                light_delta_reg <= s_tdata[279:248];
            end else if (cmd == CMD_EMIT) begin
                u_accum_reg     <= u_accum_reg + u_delta_reg;
                v_accum_reg     <= v_accum_reg + v_delta_reg;
                z_accum_reg     <= z_accum_reg + z_delta_reg;
                light_accum_reg <= light_accum_reg + light_delta_reg;
            end
        end
    end

endmodule

// ===== rtl/tspg_queue.sv =====
// ----------------------------------------------------------------------------
// tspg_queue
// Two-entry queue between front and back.
// ----------------------------------------------------------------------------
module tspg_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  tspg_pkg::work_t wdata,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output tspg_pkg::work_t rdata
);
    import tspg_pkg::*;

    work_t      entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign rdata = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== rtl/tspg_back.sv =====
// ----------------------------------------------------------------------------
// tspg_back
// Carries out queued work: table loads, perspective divide, lookups, output.
// ----------------------------------------------------------------------------
module tspg_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  tspg_pkg::cfg_t  cfg,
    input  logic            q_empty,
    input  tspg_pkg::work_t q_rdata,
    output logic            q_pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,
    output logic            m_tuser
);
    import tspg_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DIV, ST_ADDR, ST_TEX, ST_FADE, ST_OUT
    } state_t;

    logic [7:0] tex_mem  [2**TEX_AW];
    logic [7:0] fade_mem [2**FADE_AW];

    state_t            state_reg;
    logic [4:0]        iter_reg;
    logic [ACC_W-1:0]  au_reg, av_reg, rem_u_reg, rem_v_reg, mb_reg;
    logic              neg_u_reg, neg_v_reg, zero_reg;
    logic [ACC_W-1:0]  u_reg, v_reg;
    logic [7:0]        light_row_reg;
    logic [TEX_AW-1:0] tex_addr_reg;
    logic [7:0]        texel_reg, fade_q_reg;
    logic              trans_reg;
    logic              m_tvalid_reg;
    logic [7:0]        pixel_reg;
    logic              we_reg;

    logic [ACC_W:0]    trial_u, trial_v;
    logic              fit_u, fit_v;
    logic [ACC_W-1:0]  quo_u, quo_v;
    logic              out_free;

    assign trial_u  = {rem_u_reg, au_reg[ACC_W-1]};
    assign trial_v  = {rem_v_reg, av_reg[ACC_W-1]};
    assign fit_u    = trial_u >= {1'b0, mb_reg};
    assign fit_v    = trial_v >= {1'b0, mb_reg};
    // dividend registers hold the quotient once all bits are shifted through
    assign quo_u    = zero_reg ? '0 : (neg_u_reg ? -au_reg : au_reg);
    assign quo_v    = zero_reg ? '0 : (neg_v_reg ? -av_reg : av_reg);
    assign out_free = !m_tvalid_reg || m_tready;
    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = pixel_reg;
    assign m_tuser  = we_reg;

    always_ff @(posedge aclk) begin
        if (q_pop && q_rdata.cmd == CMD_LOAD_TEXEL) begin
            tex_mem[q_rdata.addr[TEX_AW-1:0]] <= q_rdata.data;
        end
        if (state_reg == ST_TEX) begin
            texel_reg <= tex_mem[tex_addr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && q_rdata.cmd == CMD_LOAD_FADE) begin
            fade_mem[q_rdata.addr] <= q_rdata.data;
        end
        if (state_reg == ST_FADE) begin
            fade_q_reg <= fade_mem[{light_row_reg, texel_reg}];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            iter_reg     <= '0;
        end else begin
            // the output step sets valid itself when it refills the register
            if (m_tvalid_reg && m_tready && state_reg != ST_OUT) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_pop && q_rdata.cmd == CMD_EMIT) begin
                        u_reg         <= q_rdata.u;
                        v_reg         <= q_rdata.v;
                        light_row_reg <= q_rdata.light_row;
                        au_reg        <= q_rdata.u[ACC_W-1] ? -q_rdata.u : q_rdata.u;
                        av_reg        <= q_rdata.v[ACC_W-1] ? -q_rdata.v : q_rdata.v;
                        mb_reg        <= q_rdata.z[ACC_W-1] ? -q_rdata.z : q_rdata.z;
                        neg_u_reg     <= q_rdata.u[ACC_W-1] ^ q_rdata.z[ACC_W-1];
                        neg_v_reg     <= q_rdata.v[ACC_W-1] ^ q_rdata.z[ACC_W-1];
                        zero_reg      <= (q_rdata.z == '0);
                        rem_u_reg     <= '0;
                        rem_v_reg     <= '0;
                        iter_reg      <= '0;
                        state_reg     <= cfg.perspective_on ? ST_DIV : ST_ADDR;
                    end
                end
                ST_DIV: begin
                    // one quotient bit per cycle for both coordinates
                    rem_u_reg <= fit_u ? trial_u[ACC_W-1:0] - mb_reg : trial_u[ACC_W-1:0];
                    rem_v_reg <= fit_v ? trial_v[ACC_W-1:0] - mb_reg : trial_v[ACC_W-1:0];
                    au_reg    <= {au_reg[ACC_W-2:0], fit_u};
                    av_reg    <= {av_reg[ACC_W-2:0], fit_v};
                    iter_reg  <= iter_reg + 5'd1;
                    if (iter_reg == 5'd31) begin
                        state_reg <= ST_ADDR;
                    end
                end
                ST_ADDR: begin
                    if (cfg.perspective_on) begin
                        tex_addr_reg <= {quo_v[11:6], quo_u[5:0]};
                    end else begin
                        tex_addr_reg <= {v_reg[27:22], u_reg[21:16]};
                    end
                    state_reg <= ST_TEX;
                end
                ST_TEX: begin
                    state_reg <= ST_FADE;
                end
                ST_FADE: begin
                    trans_reg <= cfg.transp_en
                                 && (texel_reg == cfg.transparent_index);
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        we_reg       <= !trans_reg;
                        if (trans_reg) begin
                            pixel_reg <= 8'd0;
                        end else if (cfg.lighting_on) begin
                            pixel_reg <= fade_q_reg;
                        end else begin
                            pixel_reg <= texel_reg;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/textured_span_pixel_generator_unit.sv =====
// ----------------------------------------------------------------------------
// textured_span_pixel_generator_unit
// Texture-mapped span pixel generator with perspective divide and fade lookup.
// ----------------------------------------------------------------------------
// Requests enter through a two-entry queue; a texel or fade load is written to
// its table as it leaves the queue and a span start never enters it, since the
// front end keeps the accumulators. After leaving the queue a pixel request
// passes through the address, texel read, fade read and output steps, in
// perspective mode preceded by the bit-serial divider that produces one quotient
// bit of u/z and v/z per cycle; while the previous pixel still waits for m_tready
// the back end holds in its last step. Texel and fade tables are single-port
// memories with registered reads; their contents are undefined until loaded.
// A finished pixel waits in the output register without blocking new requests
// from entering the queue.
module textured_span_pixel_generator_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // table_address, table_data, u_start, v_start, z_start, light_start,
    // u_step, v_step, z_step, light_step
    input  logic [tspg_pkg::PAYLOAD_W-1:0] s_tdata,
    // command
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // pixel
    output logic [7:0]                     m_tdata,
    // write_enable
    output logic                           m_tuser,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [3:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import tspg_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t reg_idx;
    logic     q_full, q_push, q_pop, q_empty;
    work_t    q_wdata, q_rdata;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.transp_en         <= 1'b0;
            cfg_reg.perspective_on    <= 1'b1;
            cfg_reg.lighting_on       <= 1'b1;
            cfg_reg.transparent_index <= 8'd255;
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_idx)
                REG_TRANSPARENCY: cfg_reg.transp_en         <= pwdata[0];
                REG_PERSPECTIVE:  cfg_reg.perspective_on    <= pwdata[0];
                REG_LIGHTING:     cfg_reg.lighting_on       <= pwdata[0];
                REG_TRANS_INDEX:  cfg_reg.transparent_index <= pwdata[7:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_TRANSPARENCY: prdata = {31'd0, cfg_reg.transp_en};
            REG_PERSPECTIVE:  prdata = {31'd0, cfg_reg.perspective_on};
            REG_LIGHTING:     prdata = {31'd0, cfg_reg.lighting_on};
            REG_TRANS_INDEX:  prdata = {24'd0, cfg_reg.transparent_index};
            default:          prdata = 32'd0;
        endcase
    end

    tspg_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    tspg_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .full    (q_full),
        .pop     (q_pop),
        .empty   (q_empty),
        .rdata   (q_rdata)
    );

    tspg_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_rdata  (q_rdata),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== test/tspg_checker.sv =====
// ----------------------------------------------------------------------------
// tspg_checker
// Watches the request and pixel channels of the span pixel generator, keeps
// its own copy of the texture, fade table, accumulators and settings, and
// compares every returned pixel with the predicted one.
// ----------------------------------------------------------------------------
module tspg_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [279:0] s_tdata,
    input  logic [1:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [7:0]   m_tdata,
    input  logic         m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic         pready,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output int           mismatches,
    output int           pixels_pending
);
    import tspg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] pixel;
        logic       write_enable;
    } pixel_t;

    logic [7:0]  texels [0:4095];
    logic [7:0]  fades [0:65535];
    logic [31:0] u_acc, v_acc, z_acc, l_acc, u_inc, v_inc, z_inc, l_inc;
    cfg_t        cfg;
    pixel_t      expected_pixels [$];

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // truncating signed divide, zero divisor gives zero
    function automatic logic [31:0] div_trunc(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ma, mb, q;
        if (b == '0) return '0;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q = ma / mb;
        return (a[31] ^ b[31]) ? -q : q;
    endfunction

    function automatic pixel_t shade_pixel();
        logic [31:0] row, col;
        logic [7:0]  texel;
        pixel_t      p;
        if (cfg.perspective_on) begin
            row = div_trunc(v_acc, z_acc) & 32'd4032;
            col = div_trunc(u_acc, z_acc) & 32'd63;
        end else begin
            row = (v_acc >> 16) & 32'd4032;
            col = (u_acc >> 16) & 32'd63;
        end
        texel = texels[row[11:0] + col[11:0]];
        if (cfg.transp_en && texel == cfg.transparent_index) begin
            p.pixel = 8'd0;
            p.write_enable = 1'b0;
        end else begin
            p.pixel = cfg.lighting_on ? fades[{l_acc[15:8], 8'd0} + texel] : texel;
            p.write_enable = 1'b1;
        end
        return p;
    endfunction

    always @(posedge aclk) begin
        pixel_t got;
        pixel_t want;
        if (!aresetn) begin
            {u_acc, v_acc, z_acc, l_acc, u_inc, v_inc, z_inc, l_inc} = '0;
            cfg = '{transp_en: 1'b0, perspective_on: 1'b1, lighting_on: 1'b1,
                    transparent_index: 8'hff};
            expected_pixels.delete();
            mismatches = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_TRANSPARENCY: cfg.transp_en = pwdata[0];
                    REG_PERSPECTIVE:  cfg.perspective_on = pwdata[0];
                    REG_LIGHTING:     cfg.lighting_on = pwdata[0];
                    REG_TRANS_INDEX:  cfg.transparent_index = pwdata[7:0];
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = '{pixel: m_tdata, write_enable: m_tuser};
                if (expected_pixels.size() == 0) begin
                    report($sformatf("unexpected pixel %0h/%0b", m_tdata, m_tuser));
                end else begin
                    want = expected_pixels.pop_front();
                    if (got.pixel !== want.pixel)
                        report($sformatf("pixel %0h, want %0h", got.pixel, want.pixel));
                    if (got.write_enable !== want.write_enable)
                        report($sformatf("write_enable %0b, want %0b",
                                         got.write_enable, want.write_enable));
                end
            end
            if (s_tvalid && s_tready) begin
                case (cmd_t'(s_tuser))
                    CMD_LOAD_TEXEL: texels[s_tdata[11:0]] = s_tdata[23:16];
                    CMD_LOAD_FADE:  fades[s_tdata[15:0]] = s_tdata[23:16];
                    CMD_START: begin
                        u_acc = s_tdata[24 +: 32];
                        v_acc = s_tdata[56 +: 32] << 6;
                        z_acc = s_tdata[88 +: 32];
                        l_acc = s_tdata[120 +: 32];
                        u_inc = s_tdata[152 +: 32];
                        v_inc = s_tdata[184 +: 32] << 6;
                        z_inc = s_tdata[216 +: 32];
                        l_inc = s_tdata[248 +: 32];
                    end
                    CMD_EMIT: begin
                        expected_pixels.push_back(shade_pixel());
                        u_acc += u_inc;
                        v_acc += v_inc;
                        z_acc += z_inc;
                        l_acc += l_inc;
                    end
                endcase
            end
        end
        pixels_pending = expected_pixels.size();
    end
endmodule

// ===== test/textured_span_pixel_generator_unit_tb.sv =====
// ----------------------------------------------------------------------------
// textured_span_pixel_generator_unit_tb
// Fills the low texture rows and the fade rows that spans reach, then runs
// directed and random spans under several mode settings with random stalls
// on both channels.
// ----------------------------------------------------------------------------
module textured_span_pixel_generator_unit_tb;
    import tspg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [279:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [7:0]   m_tdata;
    logic         m_tuser;
    logic         psel = 0, penable = 0, pwrite = 0;
    logic [3:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    int           mismatches, pixels_pending;
    bit           sink_steady = 0, sink_hold = 0;
    bit           persp_mode = 1;

    always #5 aclk = ~aclk;

    textured_span_pixel_generator_unit dut (.*);
    tspg_checker chk (.*);

    // sink side: random stalls, steady stretches, and one long hold-off
    initial begin
        forever begin
            @(negedge aclk);
            if (sink_hold) m_tready <= 0;
            else m_tready <= sink_steady || ($urandom_range(99) >= 26);
        end
    end

    task automatic send(input cmd_t c, input logic [279:0] d, input bit steady);
        if (!steady) begin
            while ($urandom_range(99) < 26) @(negedge aclk);
        end
        s_tvalid = 1;
        s_tuser = c;
        s_tdata = d;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        s_tvalid = 0;
    endtask

    task automatic load(input cmd_t c, input logic [15:0] a, input logic [7:0] b);
        send(c, {256'd0, b, a}, 0);
    endtask

    task automatic start_span(input logic [31:0] u, v, z, l, du, dv, dz, dl);
        send(CMD_START, {dl, dz, dv, du, l, z, v, u, 24'd0}, 0);
    endtask

    task automatic emit(input bit steady);
        send(CMD_EMIT, {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, 24'($urandom)}, steady);
    endtask

    task automatic write_reg(input reg_idx_t r, input logic [31:0] value);
        while (pixels_pending != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
        psel <= 1; pwrite <= 1; paddr <= {r, 2'b00}; pwdata <= value;
        @(negedge aclk);
        penable <= 1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        if (r == REG_PERSPECTIVE) persp_mode = value[0];
    endtask

    // texel values are kept to a set whose fade entries are all loaded
    function automatic logic [7:0] pick_texel();
        logic [7:0] t;
        t = 8'($urandom_range(32));
        return (t == 8'd32) ? 8'hff : t;
    endfunction

    function automatic logic [31:0] quot(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ma, mb, q;
        if (b == '0) return '0;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q = ma / mb;
        return (a[31] ^ b[31]) ? -q : q;
    endfunction

    function automatic logic [11:0] texel_addr(input logic [31:0] u, input logic [31:0] v,
                                               input logic [31:0] z);
        logic [31:0] qu, qv;
        if (persp_mode) begin
            qu = quot(u, z);
            qv = quot(v, z);
        end else begin
            qu = u >> 16;
            qv = v >> 16;
        end
        return {qv[11:6], qu[5:0]};
    endfunction

    // span ends early once it would leave the loaded texture rows
    task automatic random_span(input int n);
        logic [31:0] u, v, z, l, du, dv, dz, dl, va, dva;
        logic [11:0] addr;
        u = $urandom;
        du = $urandom;
        l = {16'($urandom), 6'd0, 2'($urandom), 8'($urandom)};
        dl = {16'($urandom), 16'd0};
        if (persp_mode) begin
            z = $urandom_range(1 << 16, 1 << 20);
            v = $urandom_range(0, 3 * z);
            dv = $urandom_range(255);
            dz = $urandom_range(255);
            if ($urandom_range(7) == 0) z = '0;
            if ($urandom_range(1) == 1) begin
                v = -v; z = -z; dv = -dv; dz = -dz;
            end
        end else begin
            z = $urandom;
            dz = $urandom;
            v = {10'($urandom), 4'd0, 2'($urandom), 16'($urandom)};
            dv = $urandom_range(2047);
        end
        start_span(u, v, z, l, du, dv, dz, dl);
        va = v << 6;
        dva = dv << 6;
        for (int i = 0; i < n; i++) begin
            addr = texel_addr(u, va, z);
            if (addr[11:8] != 4'd0) break;
            emit(0);
            u += du;
            va += dva;
            z += dz;
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);
        sink_steady = 1;
        for (int a = 0; a < 256; a++) send(CMD_LOAD_TEXEL, {256'd0, pick_texel(), 16'(a)}, 1);
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 33; c++) begin
                send(CMD_LOAD_FADE, {256'd0, 8'($urandom), 6'd0, 2'(r),
                                     (c == 32) ? 8'hff : 8'(c)}, 1);
            end
        end
        sink_steady = 0;
        // directed: address wrap, known texels, zero depth, quotient overflow
        load(CMD_LOAD_TEXEL, 16'hffff, 8'hff);
        load(CMD_LOAD_TEXEL, 16'h0000, 8'h00);
        load(CMD_LOAD_TEXEL, 16'h0fc0, 8'h11);
        load(CMD_LOAD_FADE, 16'hff00, 8'hff);
        load(CMD_LOAD_FADE, 16'h00ff, 8'h5a);
        start_span(0, 0, 0, 32'hffff_ffff, 0, 0, 0, 0);
        emit(0);
        start_span(32'h8000_0000, 32'h8000_0000, 32'hffff_ffff, 0, 32'h7fff_ffff,
                   32'h7fff_ffff, 1, 32'h8000_0000);
        emit(0); emit(0);
        start_span(32'h003f_0000, 32'h03ff_ffff, 1, 32'h00ff_00ff, 32'hffff_ffff,
                   32'hffff_ffff, 32'hffff_ffff, 32'h7fff_ffff);
        emit(0); emit(0);
        write_reg(REG_TRANSPARENCY, 32'd1);
        write_reg(REG_TRANS_INDEX, 32'd0);
        write_reg(REG_PERSPECTIVE, 32'd0);
        write_reg(REG_LIGHTING, 32'd0);
        start_span(0, 0, 0, 0, 32'h0001_0000, 32'h0001_0000, 0, 32'h100);
        emit(0); emit(0); emit(0);
        write_reg(REG_TRANS_INDEX, 32'd255);
        start_span(32'h003f_0000, 32'h003f_0000, 0, 0, 0, 0, 0, 0);
        emit(0);
        // pressure: sink holds off while requests keep coming
        fork
            begin
                sink_hold = 1;
                repeat (400) @(negedge aclk);
                sink_hold = 0;
            end
            random_span(16);
        join
        for (int phase = 0; phase < 6; phase++) begin
            write_reg(REG_TRANSPARENCY, $urandom_range(1));
            write_reg(REG_PERSPECTIVE, (phase % 3 != 0) ? 32'd1 : 32'd0);
            write_reg(REG_LIGHTING, $urandom_range(1));
            write_reg(REG_TRANS_INDEX, 32'(pick_texel()));
            if (phase == 2) sink_steady = 1;
            for (int k = 0; k < 20; k++) begin
                if ($urandom_range(9) == 0)
                    load(CMD_LOAD_TEXEL, {4'($urandom), 4'd0, 8'($urandom)}, pick_texel());
                if ($urandom_range(9) == 0)
                    load(CMD_LOAD_FADE, {6'd0, 2'($urandom), pick_texel()}, 8'($urandom));
                random_span($urandom_range(1, 24));
            end
            sink_steady = 0;
        end
        while (pixels_pending != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
        if (mismatches == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #8ms;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/tspg_pkg.sv
rtl/tspg_front.sv
rtl/tspg_queue.sv
rtl/tspg_back.sv
rtl/textured_span_pixel_generator_unit.sv
test/tspg_checker.sv
test/textured_span_pixel_generator_unit_tb.sv
